// ----- hdl/iad_pkg.sv -----
// Shared types and constants for the integer atan2 angle block.
`default_nettype none
package iad_pkg;

  localparam int FRAC_BITS      = 15;
  localparam int DIV_STEPS      = 3;
  localparam int DIV_STAGES     = FRAC_BITS / DIV_STEPS;
  localparam int COORD_BITS_DEF = 15;
  localparam int SCALE_BITS     = 7;
  localparam int ANGLE_BITS     = 16;
  localparam int OCTANT_BITS    = 3;

  localparam logic [SCALE_BITS-1:0] SCALE_RESET = 7'd10;
  localparam logic [8:0]            DEG_PER_TURN = 9'd360;

  localparam int HALF_TURN    = 16384;
  localparam int FULL_TURN    = 32768;
  localparam int OCTANT_ANGLE = HALF_TURN / 4;

  // odd polynomial coefficients, highest order first
  localparam logic signed [17:0] COEF_0 = 18'sh00470;
  localparam logic signed [17:0] COEF_1 = 18'sh01029;
  localparam logic signed [17:0] COEF_2 = 18'sh01F0B;
  localparam logic signed [17:0] COEF_3 = 18'sh0364C;
  localparam logic signed [17:0] COEF_4 = 18'sh0A2FC;

  typedef struct packed {
    logic                   valid;
    logic                   yzero;
    logic                   xneg;
    logic [OCTANT_BITS-1:0] oct;
  } side_t;

endpackage
`default_nettype wire

// ----- hdl/iad_fold.sv -----
// Octant fold of the input vector into x > 0, 0 <= y < x.
`default_nettype none
module iad_fold #(
  parameter int COORD_BITS = iad_pkg::COORD_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         en,
  input  wire logic                         valid,
  input  wire logic signed [COORD_BITS-1:0] y_comp,
  input  wire logic signed [COORD_BITS-1:0] x_comp,
  output iad_pkg::side_t                    side,
  output logic [COORD_BITS+1:0]             num,
  output logic [COORD_BITS+1:0]             den
);
  localparam int W = COORD_BITS + 2;

  logic signed [W-1:0] xs, ys, tmp;
  logic [iad_pkg::OCTANT_BITS-1:0] oct;

  always_comb begin
    xs  = W'(x_comp);
    ys  = W'(y_comp);
    oct = '0;
    tmp = '0;
    if (ys < 0) begin
      xs  = -xs;
      ys  = -ys;
      oct = oct + 3'd4;
    end
    if (xs <= 0) begin
      tmp = xs;
      xs  = ys;
      ys  = -tmp;
      oct = oct + 3'd2;
    end
    if (xs <= ys) begin
      tmp = ys - xs;
      xs  = xs + ys;
      ys  = tmp;
      oct = oct + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      side <= '0;
    end else if (en) begin
      side.valid <= valid;
      side.yzero <= (y_comp == '0);
      side.xneg  <= x_comp[COORD_BITS-1];
      side.oct   <= oct;
    end
    if (en) begin
      num <= ys;
      den <= xs;
    end
  end
endmodule
`default_nettype wire

// ----- hdl/iad_div.sv -----
// Pipelined restoring divider forming y/x with fifteen fraction bits.
`default_nettype none
module iad_div #(
  parameter int COORD_BITS = iad_pkg::COORD_BITS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       en,
  input  wire iad_pkg::side_t             side_in,
  input  wire logic [COORD_BITS+1:0]      num,
  input  wire logic [COORD_BITS+1:0]      den_in,
  output iad_pkg::side_t                  side_out,
  output logic [iad_pkg::FRAC_BITS-1:0]   quot
);
  localparam int W  = COORD_BITS + 2;
  localparam int QB = iad_pkg::FRAC_BITS;
  localparam int NS = iad_pkg::DIV_STAGES;

  logic [W-1:0]   rem [0:NS];
  logic [W-1:0]   den [0:NS-1];
  logic [QB-1:0]  quo [0:NS];
  iad_pkg::side_t sd  [0:NS];

  assign rem[0] = num;
  assign den[0] = den_in;
  assign quo[0] = '0;
  assign sd[0]  = side_in;

  for (genvar s = 0; s < NS; s++) begin : g_stage
    logic [W-1:0]  r_next;
    logic [QB-1:0] q_next;

    always_comb begin
      r_next = rem[s];
      q_next = quo[s];
      for (int k = 0; k < iad_pkg::DIV_STEPS; k++) begin
        r_next = {r_next[W-2:0], 1'b0};
        if (r_next >= den[s]) begin
          r_next = r_next - den[s];
          q_next = {q_next[QB-2:0], 1'b1};
        end else begin
          q_next = {q_next[QB-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        sd[s+1] <= '0;
      end else if (en) begin
        sd[s+1] <= sd[s];
      end
      if (en) begin
        rem[s+1] <= r_next;
        quo[s+1] <= q_next;
      end
    end

    if (s < NS - 1) begin : g_den
      always_ff @(posedge clk) begin
        if (en) begin
          den[s+1] <= den[s];
        end
      end
    end
  end

  assign side_out = sd[NS];
  assign quot     = quo[NS];
endmodule
`default_nettype wire

// ----- hdl/iad_poly.sv -----
// Horner evaluation of the arctangent polynomial and octant offset.
`default_nettype none
module iad_poly (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               en,
  input  wire iad_pkg::side_t                     side_in,
  input  wire logic [iad_pkg::FRAC_BITS-1:0]      t_in,
  output iad_pkg::side_t                          side_out,
  output logic signed [iad_pkg::ANGLE_BITS-1:0]   angle
);
  localparam int FB = iad_pkg::FRAC_BITS;

  iad_pkg::side_t sd [1:7];
  logic [FB-1:0]  t  [1:6];
  logic [2*FB-1:0] sq;
  logic signed [16:0] t2 [2:5];
  logic signed [35:0] m3, m4, m5, m6, m7;

  logic signed [17:0] p4, p5, p6, p7, p8;
  logic signed [17:0] ang_raw;
  logic signed [17:0] ang_wrap;
  logic signed [16:0] t2_next;
  logic signed [35:0] msq;

  always_comb begin
    msq     = -$signed({6'd0, sq});
    t2_next = 17'(msq >>> FB);
    p4 = iad_pkg::COEF_1 + 18'(m3 >>> FB);
    p5 = iad_pkg::COEF_2 + 18'(m4 >>> FB);
    p6 = iad_pkg::COEF_3 + 18'(m5 >>> FB);
    p7 = iad_pkg::COEF_4 + 18'(m6 >>> FB);
    p8 = 18'(m7 >>> FB);
    ang_raw = 18'($signed({15'd0, sd[7].oct}) * iad_pkg::OCTANT_ANGLE)
            + ((p8 + 18'sd4) >>> 3);
    if (sd[7].yzero) begin
      ang_raw = sd[7].xneg ? 18'(iad_pkg::HALF_TURN) : 18'sd0;
    end
    ang_wrap = ang_raw;
    if (ang_raw > 18'(iad_pkg::HALF_TURN)) begin
      ang_wrap = ang_raw - 18'(iad_pkg::FULL_TURN);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sd[1]    <= '0;
      sd[2]    <= '0;
      sd[3]    <= '0;
      sd[4]    <= '0;
      sd[5]    <= '0;
      sd[6]    <= '0;
      sd[7]    <= '0;
      side_out <= '0;
    end else if (en) begin
      sd[1]    <= side_in;
      sd[2]    <= sd[1];
      sd[3]    <= sd[2];
      sd[4]    <= sd[3];
      sd[5]    <= sd[4];
      sd[6]    <= sd[5];
      sd[7]    <= sd[6];
      side_out <= sd[7];
    end
    if (en) begin
      t[1]  <= t_in;
      sq    <= t_in * t_in;
      t[2]  <= t[1];
      t2[2] <= t2_next;
      t[3]  <= t[2];
      t2[3] <= t2[2];
      m3    <= 36'(t2[2] * iad_pkg::COEF_0);
      t[4]  <= t[3];
      t2[4] <= t2[3];
      m4    <= 36'(t2[3] * p4);
      t[5]  <= t[4];
      t2[5] <= t2[4];
      m5    <= 36'(t2[4] * p5);
      t[6]  <= t[5];
      m6    <= 36'(t2[5] * p6);
      m7    <= 36'(p7 * $signed({1'b0, t[6]}));
      angle <= ang_wrap[iad_pkg::ANGLE_BITS-1:0];
    end
  end
endmodule
`default_nettype wire

// ----- hdl/integer_atan2_degrees.sv -----
// Top level: atan2 of a vector in scaled degrees, fully pipelined.
//
//  channel  | beat signals                | payload
//  ---------+-----------------------------+----------------------------
//  vector   | vec_valid / vec_stall       | y_comp, x_comp
//  angle    | angle_valid / angle_stall   | angle_scaled
//  scale    | scale_we                    | scale_data
//
// One beat enters per cycle while no angle stall holds the pipeline; register stages are fold 1, divider 5
// (three quotient bits per stage), polynomial 8 (squaring, five Horner
// products, offset and wrap), scale multiply 1, rounding 1.
// Reset clears all valid bits and loads a scale of 10.
// A stall while an angle beat waits holds the whole pipeline and stalls the vector side.
`default_nettype none
module integer_atan2_degrees #(
  parameter int COORD_BITS = iad_pkg::COORD_BITS_DEF
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   vec_valid,
  output logic                                        vec_stall,
  input  wire logic signed [COORD_BITS-1:0]           y_comp,
  input  wire logic signed [COORD_BITS-1:0]           x_comp,
  output logic                                        angle_valid,
  input  wire logic                                   angle_stall,
  output logic signed [iad_pkg::ANGLE_BITS-1:0]       angle_scaled,
  input  wire logic                                   scale_we,
  input  wire logic [iad_pkg::SCALE_BITS-1:0]         scale_data
);
  localparam int W = COORD_BITS + 2;

  logic                              en;
  logic [iad_pkg::SCALE_BITS-1:0]    degree_scale;
  logic [15:0]                       k;
  iad_pkg::side_t                    fold_side, div_side, poly_side, mul_side;
  logic [W-1:0]                      num, den;
  logic [iad_pkg::FRAC_BITS-1:0]     quot;
  logic signed [iad_pkg::ANGLE_BITS-1:0] angle;
  logic signed [31:0]                prod;
  logic [31:0]                       mag;
  logic [16:0]                       q;
  logic [16:0]                       res;

  assign en        = !(angle_valid && angle_stall);
  assign vec_stall = !en;
  assign k         = 16'(degree_scale * iad_pkg::DEG_PER_TURN);

  always_ff @(posedge clk) begin
    if (rst) begin
      degree_scale <= iad_pkg::SCALE_RESET;
    end else if (scale_we) begin
      degree_scale <= scale_data;
    end
  end

  iad_fold #(.COORD_BITS(COORD_BITS)) u_fold (
    .clk(clk), .rst(rst), .en(en), .valid(vec_valid),
    .y_comp(y_comp), .x_comp(x_comp),
    .side(fold_side), .num(num), .den(den)
  );

  iad_div #(.COORD_BITS(COORD_BITS)) u_div (
    .clk(clk), .rst(rst), .en(en),
    .side_in(fold_side), .num(num), .den_in(den),
    .side_out(div_side), .quot(quot)
  );

  iad_poly u_poly (
    .clk(clk), .rst(rst), .en(en),
    .side_in(div_side), .t_in(quot),
    .side_out(poly_side), .angle(angle)
  );

  // round half away from zero on the magnitude
  always_comb begin
    mag = prod[31] ? 32'(-prod) : 32'(prod);
    q   = 17'((mag + 32'(iad_pkg::FULL_TURN / 2)) >> iad_pkg::FRAC_BITS);
    res = prod[31] ? -q : q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mul_side    <= '0;
      angle_valid <= 1'b0;
    end else if (en) begin
      mul_side    <= poly_side;
      angle_valid <= mul_side.valid;
    end
    if (en) begin
      prod         <= 32'(angle * $signed({1'b0, k}));
      angle_scaled <= res[iad_pkg::ANGLE_BITS-1:0];
    end
  end
endmodule
`default_nettype wire

// ----- tb/sv/testbench.sv -----
// Self-checking testbench for the integer atan2 angle block.
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // Integer model of the block: folded octant, fixed-point polynomial,
  // then scaling to degrees with rounding half away from zero.
  class angle_scoreboard;
    int unsigned scale;
    logic signed [15:0] pending_angles[$];
    int errors;
    int checked;

    function new();
      scale = iad_pkg::SCALE_RESET;
      errors = 0;
      checked = 0;
    endfunction

    static function longint floor_shift(longint v, int s);
      return v >>> s;
    endfunction

    static function int turn_units(int xi, int yi);
      int oct;
      int tmp;
      longint t;
      longint t2;
      longint p;
      oct = 0;
      if (yi == 0) return (xi >= 0) ? 0 : iad_pkg::HALF_TURN;
      if (yi < 0) begin
        xi = -xi;
        yi = -yi;
        oct += 4;
      end
      if (xi <= 0) begin
        tmp = xi;
        xi = yi;
        yi = -tmp;
        oct += 2;
      end
      if (xi <= yi) begin
        tmp = yi - xi;
        xi = xi + yi;
        yi = tmp;
        oct += 1;
      end
      t = (longint'(yi) << iad_pkg::FRAC_BITS) / xi;
      t2 = floor_shift(-(t * t), iad_pkg::FRAC_BITS);
      p = 'h0470;
      p = 'h1029 + floor_shift(t2 * p, iad_pkg::FRAC_BITS);
      p = 'h1F0B + floor_shift(t2 * p, iad_pkg::FRAC_BITS);
      p = 'h364C + floor_shift(t2 * p, iad_pkg::FRAC_BITS);
      p = 'hA2FC + floor_shift(t2 * p, iad_pkg::FRAC_BITS);
      p = floor_shift(p * t, iad_pkg::FRAC_BITS);
      return oct * iad_pkg::OCTANT_ANGLE + int'(floor_shift(p + 4, 3));
    endfunction

    function void note_vector(logic signed [14:0] y, logic signed [14:0] x);
      int ang;
      longint prod;
      longint mag;
      longint q;
      ang = turn_units(int'(x), int'(y));
      if (ang > iad_pkg::HALF_TURN) ang -= iad_pkg::FULL_TURN;
      prod = longint'(ang) * 360 * scale;
      mag = (prod < 0) ? -prod : prod;
      q = (mag + iad_pkg::FULL_TURN / 2) / iad_pkg::FULL_TURN;
      pending_angles.push_back(16'((prod < 0) ? -q : q));
    endfunction

    function void check_angle(logic signed [15:0] got);
      logic signed [15:0] want;
      if (pending_angles.size() == 0) begin
        $display("%0t: angle %0d with none expected", $time, got);
        errors++;
        return;
      end
      want = pending_angles.pop_front();
      checked++;
      if (got !== want) begin
        $display("%0t: angle_scaled expected %0d actual %0d", $time, want, got);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic vec_valid = 0;
  logic vec_stall;
  logic signed [14:0] y_comp = 0;
  logic signed [14:0] x_comp = 0;
  logic angle_valid;
  logic angle_stall = 0;
  logic signed [15:0] angle_scaled;
  logic scale_we = 0;
  logic [6:0] scale_data = 0;

  angle_scoreboard sb = new();
  int idle_pct = 0;
  int stall_pct = 0;
  longint cycles = 0;
  int sent = 0;

  integer_atan2_degrees #(.COORD_BITS(15)) i_dut (
    .clk(clk), .rst(rst),
    .vec_valid(vec_valid), .vec_stall(vec_stall),
    .y_comp(y_comp), .x_comp(x_comp),
    .angle_valid(angle_valid), .angle_stall(angle_stall),
    .angle_scaled(angle_scaled),
    .scale_we(scale_we), .scale_data(scale_data)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("integer_atan2_degrees verification failed");
      $finish;
    end
    if (!rst && angle_valid && !angle_stall) sb.check_angle(angle_scaled);
    if (!rst && vec_valid && !vec_stall) sb.note_vector(y_comp, x_comp);
  end

  // randomise stall on the receiving side at every falling edge
  always @(negedge clk)
    angle_stall <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);

  // leave valid high on return so the next beat can follow with no gap
  task automatic send_vector(int y, int x);
    while ((idle_pct > 0) && ($urandom_range(99) < idle_pct)) begin
      vec_valid <= 0;
      @(negedge clk);
    end
    y_comp <= 15'(y);
    x_comp <= 15'(x);
    vec_valid <= 1;
    @(posedge clk);
    while (vec_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    vec_valid <= 0;
    while (sb.pending_angles.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic set_scale(int s);
    drain();
    scale_data <= 7'(s);
    scale_we <= 1;
    @(negedge clk);
    scale_we <= 0;
    sb.scale = s;
  endtask

  function automatic int rand_coord();
    case ($urandom_range(5))
      0: return $urandom_range(32767) - 16384;
      1: return $urandom_range(16) - 8;
      2: return ($urandom_range(1) ? 16383 : -16383);
      default: return $urandom_range(32766) - 16383;
    endcase
  endfunction

  initial begin
    int ext[5] = '{0, 1, -1, 16383, -16383};
    int scales[6] = '{10, 1, 100, 127, 0, 37};
    repeat (3) @(negedge clk);
    rst <= 0;
    // directed: axes, diagonals, most negative code, origin
    foreach (ext[i]) foreach (ext[j]) begin
      send_vector(ext[i], ext[j]);
      sent++;
    end
    send_vector(-16384, -16384);
    send_vector(-16384, 5);
    sent += 2;
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin idle_pct = 0; stall_pct = 0; end
        1: begin idle_pct = 81; stall_pct = 0; end
        2: begin idle_pct = 0; stall_pct = 81; end
        default: begin idle_pct = 23; stall_pct = 23; end
      endcase
      if (ph < 6) set_scale(scales[ph]);
      else set_scale($urandom_range(127));
      for (int k = 0; k < 200; k++) begin
        int a;
        a = rand_coord();
        // hold on one diagonal now and then to hit octant boundaries
        if ($urandom_range(9) == 0) send_vector(a, ($urandom_range(1) ? a : -a));
        else send_vector(a, rand_coord());
        sent++;
        if (k == 100) drain();
      end
    end
    drain();
    $display("Sent %0d vectors over 8 scale settings and four handshake pressures;", sent);
    $display("checked %0d angles.", sb.checked);
    if (sb.errors == 0 && sb.pending_angles.size() == 0)
      $display("integer_atan2_degrees verification clean");
    else
      $display("integer_atan2_degrees verification failed");
    $finish;
  end
endmodule
`default_nettype wire
